// File: rtl/swmf_pkg.sv
// Shared types and constants of the slice-weighted mask fraction block.
// No dependencies; used by the channel interfaces, the core and its checker.
`default_nettype none

package swmf_pkg;

    // Field widths
    localparam int unsigned LOCAL_W  = 10;
    localparam int unsigned SLICE_W  = 10;
    localparam int unsigned POS_W    = 18;
    localparam int unsigned VALUE_W  = 17;
    localparam int unsigned VOXEL_W  = 11;
    localparam int unsigned FRAC_W   = 17;
    localparam int unsigned THICK_W  = 9;
    localparam int unsigned TOL_W    = 16;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 2'd0,
        CFG_ORIGIN_Y   = 2'd1,
        CFG_SLAB_THICK = 2'd2,
        CFG_OVER_TOL   = 2'd3
    } t_cfg_idx;

    // Reset values of the registers
    localparam logic [LOCAL_W-1:0] ORIGIN_RST = '0;
    localparam logic [THICK_W-1:0] THICK_RST  = 9'd256;
    localparam logic [TOL_W-1:0]   TOL_RST    = 16'd1;

    // Bounds are in 1/512 slice units (doubled positions)
    localparam int unsigned BOUND_W = 21;
    localparam int unsigned WEIGHT_W = 10;
    localparam logic signed [BOUND_W-1:0] SLICE_HALF = 21'sd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 10'd512;

    // Accumulator: products in 2^-25 units, saturating at 2^31-1
    localparam int unsigned PROD_W = VALUE_W + WEIGHT_W;
    localparam int unsigned SUM_W  = 31;
    localparam int unsigned LIMIT_W = 27;
    localparam logic [SUM_W-1:0]   SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [LIMIT_W-1:0] ONE_SUM  = 27'd33554432;
    localparam int unsigned FRAC_SHIFT = 9;
    localparam logic [FRAC_W-1:0]  FRAC_ONE = 17'h10000;

endpackage : swmf_pkg

`default_nettype wire

// File: rtl/swmf_if.sv
// Valid/ready channel interfaces for plane items and voxel results.
// Depends on swmf_pkg for field widths.
`default_nettype none

interface swmf_in_if
    import swmf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [LOCAL_W-1:0]   local_x;
    logic [LOCAL_W-1:0]   local_y;
    logic [SLICE_W-1:0]   slice_z;
    logic [POS_W-1:0]     plane_position;
    logic [VALUE_W-1:0]   plane_value;
    logic                 last_plane;

    modport source (
        output valid, local_x, local_y, slice_z, plane_position, plane_value,
               last_plane,
        input  ready
    );
    modport sink (
        input  valid, local_x, local_y, slice_z, plane_position, plane_value,
               last_plane,
        output ready
    );
endinterface : swmf_in_if

interface swmf_out_if
    import swmf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VOXEL_W-1:0]   voxel_x;
    logic [VOXEL_W-1:0]   voxel_y;
    logic [SLICE_W-1:0]   voxel_z;
    logic [FRAC_W-1:0]    volume_fraction;
    logic                 overflow_error;

    modport source (
        output valid, voxel_x, voxel_y, voxel_z, volume_fraction, overflow_error,
        input  ready
    );
    modport sink (
        input  valid, voxel_x, voxel_y, voxel_z, volume_fraction, overflow_error,
        output ready
    );
endinterface : swmf_out_if

`default_nettype wire

// File: rtl/slice_weighted_mask_fraction_core.sv
// Slice-weighted mask fraction core: per-plane slab weighting, accumulation
// and end-of-voxel judgment. Depends on swmf_pkg and swmf_if.sv.
`default_nettype none

//  Channel   Dir  Handshake             Moves
//  i_in      in   valid/ready           one plane item per transfer
//  o_out     out  valid/ready           one voxel result per transfer
//  i_cfg_*   in   write enable only     one register write per cycle
//
//  One plane item per cycle sustained while the pipe does not stall; the result
//  passes input reg -> weight -> product -> accumulate -> output.
//  The accumulate stage carries an item-to-item dependency (27-bit product
//  into a 31-bit saturating sum); the plane count in the weight stage another.
//  Reset (synchronous, active low) clears stage valids, the sum and the
//  plane count, and loads register defaults. Plane items keep flowing while
//  a result waits; the pipe stalls only while a last-plane item sits in the
//  accumulate stage and the previous result has not been taken.

module slice_weighted_mask_fraction_core
    import swmf_pkg::*;
#(
    parameter int unsigned MAX_PLANES = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    swmf_in_if.sink                i_in,
    swmf_out_if.source             o_out,
    input  wire                    i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(MAX_PLANES + 1);

    // ---------------- configuration registers ----------------
    logic [LOCAL_W-1:0] r_origin_x;
    logic [LOCAL_W-1:0] r_origin_y;
    logic [THICK_W-1:0] r_thick;
    logic [TOL_W-1:0]   r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_RST;
            r_origin_y <= ORIGIN_RST;
            r_thick    <= THICK_RST;
            r_tol      <= TOL_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:   r_origin_x <= i_cfg_wdata[LOCAL_W-1:0];
                CFG_ORIGIN_Y:   r_origin_y <= i_cfg_wdata[LOCAL_W-1:0];
                CFG_SLAB_THICK: r_thick    <= i_cfg_wdata[THICK_W-1:0];
                CFG_OVER_TOL:   r_tol      <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Only a last-plane item in the accumulate stage can load the output.
    logic advance;
    logic r_s4_valid;
    logic r_out_valid;

    assign advance   = !(r_s4_valid && r_out_valid && !o_out.ready);
    assign i_in.ready = advance;

    // ---------------- stage 1: input register ----------------
    logic               r_s1_valid;
    logic [LOCAL_W-1:0] r_s1_lx, r_s1_ly;
    logic [SLICE_W-1:0] r_s1_z;
    logic [POS_W-1:0]   r_s1_pos;
    logic [VALUE_W-1:0] r_s1_val;
    logic               r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_lx   <= i_in.local_x;
            r_s1_ly   <= i_in.local_y;
            r_s1_z    <= i_in.slice_z;
            r_s1_pos  <= i_in.plane_position;
            r_s1_val  <= i_in.plane_value;
            r_s1_last <= i_in.last_plane;
        end
    end

    // ---------------- stage 2: slab weight ----------------
    logic signed [BOUND_W-1:0] zmin, zmax, smin, smax, lo_gap, hi_gap;
    logic [WEIGHT_W-1:0]       n_weight;
    logic [CNT_W-1:0]          r_cnt;
    logic                      use_plane;

    assign use_plane = (r_cnt < CNT_W'(MAX_PLANES));

    always_comb begin
        zmin   = $signed({2'b00, r_s1_z, 9'd0}) - SLICE_HALF;
        zmax   = $signed({2'b00, r_s1_z, 9'd0}) + SLICE_HALF;
        smin   = $signed({2'b00, r_s1_pos, 1'b0}) - $signed({12'd0, r_thick});
        smax   = $signed({2'b00, r_s1_pos, 1'b0}) + $signed({12'd0, r_thick});
        lo_gap = smax - zmin;
        hi_gap = zmax - smin;
        n_weight = '0;
        if (smin < zmin && smax > zmin) begin
            // slab reaches into the slice from below, or spans it
            n_weight = (smax < zmax) ? lo_gap[WEIGHT_W-1:0] : WEIGHT_ONE;
        end else if (smin >= zmin && smin < zmax) begin
            // slab starts inside the slice
            n_weight = (smax < zmax) ? {r_thick, 1'b0} : hi_gap[WEIGHT_W-1:0];
        end
        if (!use_plane) begin
            n_weight = '0;
        end
    end

    logic                r_s2_valid;
    logic [WEIGHT_W-1:0] r_s2_w;
    logic [VALUE_W-1:0]  r_s2_val;
    logic                r_s2_last;
    logic [LOCAL_W-1:0]  r_s2_lx, r_s2_ly;
    logic [SLICE_W-1:0]  r_s2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_cnt <= '0;
                end else if (use_plane) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_w    <= n_weight;
            r_s2_val  <= r_s1_val;
            r_s2_last <= r_s1_last;
            r_s2_lx   <= r_s1_lx;
            r_s2_ly   <= r_s1_ly;
            r_s2_z    <= r_s1_z;
        end
    end

    // ---------------- stage 3: product ----------------
    logic               r_s3_valid;
    logic [PROD_W-1:0]  r_s3_prod;
    logic               r_s3_last;
    logic [LOCAL_W-1:0] r_s3_lx, r_s3_ly;
    logic [SLICE_W-1:0] r_s3_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (advance) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s3_prod <= PROD_W'(r_s2_val) * PROD_W'(r_s2_w);
            r_s3_last <= r_s2_last;
            r_s3_lx   <= r_s2_lx;
            r_s3_ly   <= r_s2_ly;
            r_s3_z    <= r_s2_z;
        end
    end

    // ---------------- stage 4: saturating accumulate ----------------
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   n_sum;
    logic [SUM_W-1:0]   r_s4_sum;
    logic [LOCAL_W-1:0] r_s4_lx, r_s4_ly;
    logic [SLICE_W-1:0] r_s4_z;

    assign sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(r_s3_prod);
    assign n_sum    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_s4_valid <= 1'b0;
        end else if (advance) begin
            r_s4_valid <= r_s3_valid && r_s3_last;
            if (r_s3_valid) begin
                r_sum <= r_s3_last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s4_sum <= n_sum;
            r_s4_lx  <= r_s3_lx;
            r_s4_ly  <= r_s3_ly;
            r_s4_z   <= r_s3_z;
        end
    end

    // ---------------- stage 5: judge and output register ----------------
    logic [LIMIT_W-1:0] limit;
    logic               over_one, over_limit, emit;
    logic [FRAC_W-1:0]  n_frac;

    assign limit      = ONE_SUM + LIMIT_W'({r_tol, 9'd0});
    assign over_one   = r_s4_sum > SUM_W'(ONE_SUM);
    assign over_limit = r_s4_sum > SUM_W'(limit);
    // zero sum gives no result; an overflow always does
    assign emit       = over_limit || (r_s4_sum != '0);

    always_comb begin
        if (over_limit) begin
            n_frac = '0;
        end else if (over_one) begin
            n_frac = FRAC_ONE;   // small overshoot snaps to one
        end else begin
            n_frac = r_s4_sum[FRAC_SHIFT +: FRAC_W];
        end
    end

    logic [VOXEL_W-1:0] r_out_x, r_out_y;
    logic [SLICE_W-1:0] r_out_z;
    logic [FRAC_W-1:0]  r_out_frac;
    logic               r_out_err;
    logic               load_out;

    assign load_out = advance && r_s4_valid && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x    <= VOXEL_W'(r_origin_x) + VOXEL_W'(r_s4_lx);
            r_out_y    <= VOXEL_W'(r_origin_y) + VOXEL_W'(r_s4_ly);
            r_out_z    <= r_s4_z;
            r_out_frac <= n_frac;
            r_out_err  <= over_limit;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.voxel_x         = r_out_x;
    assign o_out.voxel_y         = r_out_y;
    assign o_out.voxel_z         = r_out_z;
    assign o_out.volume_fraction = r_out_frac;
    assign o_out.overflow_error  = r_out_err;

endmodule : slice_weighted_mask_fraction_core

`default_nettype wire

// File: rtl/swmf_checker.sv
// Port-level checks for slice_weighted_mask_fraction_core, bound to it here.
// Depends on swmf_pkg and the core's ports.
`default_nettype none

module swmf_checker
    import swmf_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input wire [VOXEL_W-1:0]   i_voxel_x,
    input wire [VOXEL_W-1:0]   i_voxel_y,
    input wire [SLICE_W-1:0]   i_voxel_z,
    input wire [FRAC_W-1:0]    i_frac,
    input wire                 i_err
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_voxel_x) && $stable(i_voxel_y) && $stable(i_voxel_z)
            && $stable(i_frac) && $stable(i_err))
        else $error("result changed while stalled");

    // error results carry no fraction
    a_err_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err |-> i_frac == '0)
        else $error("overflow result with nonzero fraction");

    // clamping keeps the fraction at or below one
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_frac <= FRAC_ONE)
        else $error("fraction above one");

endmodule : swmf_checker

bind slice_weighted_mask_fraction_core swmf_checker u_swmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_voxel_x   (o_out.voxel_x),
    .i_voxel_y   (o_out.voxel_y),
    .i_voxel_z   (o_out.voxel_z),
    .i_frac      (o_out.volume_fraction),
    .i_err       (o_out.overflow_error)
);

`default_nettype wire
